[rtl/http_request_tokenizer_macros.svh]
// Assertion helpers shared by the checker.
`ifndef HTTP_REQUEST_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_TOKENIZER_MACROS_SVH

// Next-cycle implication, quiet while reset is asserted.
`define HTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication that is also checked across reset.
`define HTOK_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[rtl/htok_pkg.sv]
`timescale 1ns / 1ps

package htok_pkg;

    localparam int MAX_REQUEST_BYTES = 1024;
    localparam int POS_W = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int TS_W  = 10;
    localparam int LEN_W = 11;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [2:0] K_METHOD = 3'd0;
    localparam logic [2:0] K_URL    = 3'd1;
    localparam logic [2:0] K_VER    = 3'd2;
    localparam logic [2:0] K_DEFVER = 3'd3;
    localparam logic [2:0] K_KEY    = 3'd4;
    localparam logic [2:0] K_VALUE  = 3'd5;
    localparam logic [2:0] K_END    = 3'd6;
    localparam logic [2:0] K_ERROR  = 3'd7;

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_BAD_FIRST = 3'd1;
    localparam logic [2:0] E_NO_URL    = 3'd2;
    localparam logic [2:0] E_NO_COLON  = 3'd3;
    localparam logic [2:0] E_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_request;
    } in_t;

    typedef struct packed {
        logic [2:0]       token_kind;
        logic [TS_W-1:0]  token_start;
        logic [LEN_W-1:0] token_length;
        logic [2:0]       error_code;
        logic             last_of_run;
    } out_t;

    // Results produced by one accepted byte, in order.
    typedef struct packed {
        logic [1:0] cnt;
        out_t       first;
        out_t       second;
    } push_t;

endpackage

[rtl/http_request_tokenizer.sv]
// HTTP request tokenizer.
// Input channel (s_valid/s_ready/s_payload): one request byte per transfer;
// start_of_request marks offset 0 of a new request and restarts the parser.
// Result channel (m_valid/m_ready/m_payload): tokens as kind, start offset,
// length and error code; last_of_run flags the final token caused by a byte.
// A byte yields zero, one or two tokens (URL closed by CR adds a default
// version token). Each token is registered in the result queue first.
// Throughput: one byte per cycle while s_ready is high. The parser state
// updates in the cycle of the transfer; tokens go into a four-entry result
// queue, and s_ready is high while that queue has room for two tokens, so a
// receiver that is always ready never stalls the input. Two-token bytes
// leave as two transfers. When the receiver stalls, tokens wait in the queue
// with payload held, and s_ready drops once fewer than two slots are free.
// Reset (aresetn low, synchronous) empties the queue and leaves the parser
// idle: bytes without start_of_request are consumed and give no tokens.
`timescale 1ns / 1ps

module http_request_tokenizer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  htok_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output htok_pkg::out_t m_payload
);
    import htok_pkg::*;

    push_t push;
    logic  accept;

    assign accept = s_valid && s_ready;

    htok_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_item (s_payload),
        .push    (push)
    );

    htok_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

[rtl/htok_parse.sv]
`timescale 1ns / 1ps

module htok_parse (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  htok_pkg::in_t  in_item,
    output htok_pkg::push_t push
);
    import htok_pkg::*;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_METHOD   = 4'd1;
    localparam logic [3:0] PH_URL      = 4'd2;
    localparam logic [3:0] PH_VER      = 4'd3;
    localparam logic [3:0] PH_RL_SKIP  = 4'd4;
    localparam logic [3:0] PH_LINE     = 4'd5;
    localparam logic [3:0] PH_KEY      = 4'd6;
    localparam logic [3:0] PH_VAL      = 4'd7;
    localparam logic [3:0] PH_HDR_SKIP = 4'd8;
    localparam logic [3:0] PH_BLANK_CR = 4'd9;
    localparam logic [3:0] PH_DONE     = 4'd10;

    logic [3:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [TS_W-1:0]  begin_reg, begin_next;
    logic [POS_W-1:0] count_reg, count_next;

    logic [7:0]       b;
    logic [POS_W-1:0] pos_inc;
    logic [TS_W-1:0]  pos_ts;
    logic [TS_W-1:0]  pos_inc_ts;
    logic [LEN_W-1:0] count_len;

    function automatic out_t mk(input logic [2:0] kind, input logic [TS_W-1:0] start,
                                input logic [LEN_W-1:0] len, input logic [2:0] err);
        out_t r;
        r.token_kind   = kind;
        r.token_start  = start;
        r.token_length = len;
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    assign b          = in_item.data_byte;
    assign pos_inc    = pos_reg + 1'b1;
    assign pos_ts     = TS_W'(pos_reg);
    assign pos_inc_ts = TS_W'(pos_inc);
    assign count_len  = LEN_W'(count_reg);

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        begin_next  = begin_reg;
        count_next  = count_reg;
        push.cnt    = 2'd0;
        push.first  = '0;
        push.second = '0;

        if (accept) begin
            if (in_item.start_of_request) begin
                pos_next   = POS_W'(1);
                begin_next = '0;
                count_next = POS_W'(1);
                phase_next = PH_METHOD;
                if (b < CH_A || b > CH_Z) begin
                    push.cnt   = 2'd1;
                    push.first = mk(K_ERROR, '0, '0, E_BAD_FIRST);
                    phase_next = PH_DONE;
                end
            end else if (phase_reg != PH_IDLE && phase_reg != PH_DONE) begin
                if (pos_reg >= POS_W'(MAX_REQUEST_BYTES)) begin
                    push.cnt   = 2'd1;
                    push.first = mk(K_ERROR, pos_ts, '0, E_OVERFLOW);
                    phase_next = PH_DONE;
                end else begin
                    pos_next = pos_inc;
                    unique case (phase_reg)
                        PH_METHOD: begin
                            if (b == CH_SP) begin
                                push.cnt   = 2'd1;
                                push.first = mk(K_METHOD, begin_reg, count_len, E_NONE);
                                begin_next = pos_inc_ts;
                                count_next = '0;
                                phase_next = PH_URL;
                            end else if (b == CH_CR) begin
                                push.cnt   = 2'd1;
                                push.first = mk(K_ERROR, pos_ts, '0, E_NO_URL);
                                phase_next = PH_DONE;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        PH_URL: begin
                            if (b == CH_SP || b == CH_CR) begin
                                push.cnt = 2'd1;
                                if (count_reg == '0) begin
                                    push.first = mk(K_ERROR, pos_ts, '0, E_NO_URL);
                                    phase_next = PH_DONE;
                                end else begin
                                    push.first = mk(K_URL, begin_reg, count_len, E_NONE);
                                    if (b == CH_CR) begin
                                        // URL closed by CR: default version follows
                                        push.cnt    = 2'd2;
                                        push.second = mk(K_DEFVER, '0, '0, E_NONE);
                                        phase_next  = PH_RL_SKIP;
                                    end else begin
                                        begin_next = pos_inc_ts;
                                        count_next = '0;
                                        phase_next = PH_VER;
                                    end
                                end
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        PH_VER: begin
                            if (b == CH_CR) begin
                                push.cnt = 2'd1;
                                if (count_reg == '0) begin
                                    push.first = mk(K_DEFVER, '0, '0, E_NONE);
                                end else begin
                                    push.first = mk(K_VER, begin_reg, count_len, E_NONE);
                                end
                                phase_next = PH_RL_SKIP;
                            end else if (b != CH_SP) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        PH_RL_SKIP, PH_HDR_SKIP: begin
                            phase_next = PH_LINE;
                        end
                        PH_LINE: begin
                            begin_next = pos_ts;
                            if (b == CH_NUL) begin
                                push.cnt   = 2'd1;
                                push.first = mk(K_END, pos_ts, '0, E_NONE);
                                phase_next = PH_DONE;
                            end else if (b == CH_CR) begin
                                phase_next = PH_BLANK_CR;
                            end else if (b == CH_COLON) begin
                                push.cnt   = 2'd1;
                                push.first = mk(K_KEY, pos_ts, '0, E_NONE);
                                begin_next = pos_inc_ts;
                                count_next = '0;
                                phase_next = PH_VAL;
                            end else begin
                                count_next = POS_W'(1);
                                phase_next = PH_KEY;
                            end
                        end
                        PH_BLANK_CR: begin
                            if (b == CH_LF) begin
                                push.cnt   = 2'd1;
                                push.first = mk(K_END, begin_reg, '0, E_NONE);
                                phase_next = PH_DONE;
                            end else if (b == CH_COLON) begin
                                // key made of the lone CR
                                push.cnt   = 2'd1;
                                push.first = mk(K_KEY, begin_reg, LEN_W'(1), E_NONE);
                                begin_next = pos_inc_ts;
                                count_next = '0;
                                phase_next = PH_VAL;
                            end else if (b == CH_CR || b == CH_NUL) begin
                                push.cnt   = 2'd1;
                                push.first = mk(K_ERROR, pos_ts, '0, E_NO_COLON);
                                phase_next = PH_DONE;
                            end else begin
                                count_next = POS_W'(2);
                                phase_next = PH_KEY;
                            end
                        end
                        PH_KEY: begin
                            if (b == CH_COLON) begin
                                push.cnt   = 2'd1;
                                push.first = mk(K_KEY, begin_reg, count_len, E_NONE);
                                begin_next = pos_inc_ts;
                                count_next = '0;
                                phase_next = PH_VAL;
                            end else if (b == CH_CR || b == CH_NUL) begin
                                push.cnt   = 2'd1;
                                push.first = mk(K_ERROR, pos_ts, '0, E_NO_COLON);
                                phase_next = PH_DONE;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        PH_VAL: begin
                            if (b == CH_CR) begin
                                push.cnt   = 2'd1;
                                push.first = mk(K_VALUE, begin_reg, count_len, E_NONE);
                                phase_next = PH_HDR_SKIP;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        default: begin
                            phase_next = PH_DONE;
                        end
                    endcase
                end
            end
        end

        if (push.cnt == 2'd1) begin
            push.first.last_of_run = 1'b1;
        end
        if (push.cnt == 2'd2) begin
            push.second.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/htok_fifo.sv]
`timescale 1ns / 1ps

module htok_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  htok_pkg::push_t push,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output htok_pkg::out_t  m_payload
);
    import htok_pkg::*;

    out_t            q_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    logic [Q_AW-1:0] wr_ptr_plus1;
    logic            pop;

    assign pop          = m_valid && m_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + Q_AW'(push.cnt);
    assign rd_ptr_next  = rd_ptr_reg + Q_AW'(pop);
    assign count_next   = count_reg + Q_CW'(push.cnt) - Q_CW'(pop);

    // keep space for the two results one byte can produce
    assign room      = count_reg <= Q_CW'(Q_DEPTH - 2);
    assign m_valid   = count_reg != '0;
    assign m_payload = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            q_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

[rtl/htok_checker.sv]
`timescale 1ns / 1ps
`include "http_request_tokenizer_macros.svh"

module htok_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input htok_pkg::in_t  s_payload,
    input logic           m_valid,
    input logic           m_ready,
    input htok_pkg::out_t m_payload
);
    import htok_pkg::*;

    logic bad_first;
    logic stalled;
    logic pair_head;

    assign bad_first = s_valid && s_ready && s_payload.start_of_request &&
                       (s_payload.data_byte < CH_A || s_payload.data_byte > CH_Z);
    assign stalled   = m_valid && !m_ready;
    // first token of a two-token run leaves; its partner is already queued
    assign pair_head = m_valid && m_ready && !m_payload.last_of_run;

    `HTOK_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)
    `HTOK_ASSERT_NEXT(a_stall_hold, aclk, aresetn, stalled, m_valid && $stable(m_payload))
    `HTOK_ASSERT_NEXT(a_bad_first_out, aclk, aresetn, bad_first, m_valid)
    `HTOK_ASSERT_NEXT(a_pair_follows, aclk, aresetn, pair_head, m_valid)

endmodule

bind http_request_tokenizer htok_checker u_htok_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

[verif/tb_http_request_tokenizer.sv]
`timescale 1ns / 1ps

module tb_http_request_tokenizer;
    import htok_pkg::*;

    localparam int RANDOM_BYTES = 1100;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 250;

    typedef enum logic [3:0] {
        P_IDLE, P_METHOD, P_URL, P_VER, P_RL_SKIP, P_LINE,
        P_KEY, P_VAL, P_HDR_SKIP, P_BLANK_CR, P_DONE
    } parse_phase_e;

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    out_t m_payload;

    http_request_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always #6 aclk = ~aclk;

    in_t  pending_bytes[$];
    out_t expected_tokens[$];
    out_t byte_tokens[$];

    // tokenizer state mirror
    parse_phase_e phase     = P_IDLE;
    int unsigned  next_pos  = 0;
    int unsigned  tok_begin = 0;
    int unsigned  tok_count = 0;

    int   mismatches  = 0;
    int   idle_cycles = 0;
    logic calm        = 1'b0;

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Mostly short gaps, a few long ones; none at all while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_token(logic [2:0] kind, int unsigned start,
                                      int unsigned len, logic [2:0] code);
        out_t t;
        t.token_kind   = kind;
        t.token_start  = start[TS_W-1:0];
        t.token_length = len[LEN_W-1:0];
        t.error_code   = code;
        t.last_of_run  = 1'b0;
        byte_tokens.push_back(t);
    endfunction

    function automatic void abort_at(int unsigned at, logic [2:0] code);
        add_token(K_ERROR, at, 0, code);
        phase = P_DONE;
    endfunction

    function automatic void tokenize_byte(in_t item);
        logic [7:0]  b;
        int unsigned at;
        out_t        t;
        b = item.data_byte;
        byte_tokens.delete();
        if (item.start_of_request) begin
            next_pos  = 1;
            tok_begin = 0;
            tok_count = 1;
            phase     = P_METHOD;
            if (b < CH_A || b > CH_Z) abort_at(0, E_BAD_FIRST);
        end else if (phase != P_IDLE && phase != P_DONE) begin
            at = next_pos;
            if (at >= MAX_REQUEST_BYTES) begin
                abort_at(at, E_OVERFLOW);
            end else begin
                next_pos = at + 1;
                case (phase)
                    P_METHOD: begin
                        if (b == CH_SP) begin
                            add_token(K_METHOD, tok_begin, tok_count, E_NONE);
                            tok_begin = at + 1;
                            tok_count = 0;
                            phase     = P_URL;
                        end else if (b == CH_CR) begin
                            abort_at(at, E_NO_URL);
                        end else begin
                            tok_count++;
                        end
                    end
                    P_URL: begin
                        if (b == CH_SP || b == CH_CR) begin
                            if (tok_count == 0) begin
                                abort_at(at, E_NO_URL);
                            end else begin
                                add_token(K_URL, tok_begin, tok_count, E_NONE);
                                if (b == CH_CR) begin
                                    add_token(K_DEFVER, 0, 0, E_NONE);
                                    phase = P_RL_SKIP;
                                end else begin
                                    tok_begin = at + 1;
                                    tok_count = 0;
                                    phase     = P_VER;
                                end
                            end
                        end else begin
                            tok_count++;
                        end
                    end
                    P_VER: begin
                        if (b == CH_CR) begin
                            if (tok_count == 0) add_token(K_DEFVER, 0, 0, E_NONE);
                            else add_token(K_VER, tok_begin, tok_count, E_NONE);
                            phase = P_RL_SKIP;
                        end else if (b != CH_SP) begin
                            tok_count++;
                        end
                    end
                    P_RL_SKIP, P_HDR_SKIP: phase = P_LINE;
                    P_LINE: begin
                        tok_begin = at;
                        if (b == CH_NUL) begin
                            add_token(K_END, at, 0, E_NONE);
                            phase = P_DONE;
                        end else if (b == CH_CR) begin
                            phase = P_BLANK_CR;
                        end else if (b == CH_COLON) begin
                            add_token(K_KEY, at, 0, E_NONE);
                            tok_begin = at + 1;
                            tok_count = 0;
                            phase     = P_VAL;
                        end else begin
                            tok_count = 1;
                            phase     = P_KEY;
                        end
                    end
                    P_BLANK_CR: begin
                        if (b == CH_LF) begin
                            add_token(K_END, tok_begin, 0, E_NONE);
                            phase = P_DONE;
                        end else if (b == CH_COLON) begin
                            // key is the lone CR
                            add_token(K_KEY, tok_begin, 1, E_NONE);
                            tok_begin = at + 1;
                            tok_count = 0;
                            phase     = P_VAL;
                        end else if (b == CH_CR || b == CH_NUL) begin
                            abort_at(at, E_NO_COLON);
                        end else begin
                            tok_count = 2;
                            phase     = P_KEY;
                        end
                    end
                    P_KEY: begin
                        if (b == CH_COLON) begin
                            add_token(K_KEY, tok_begin, tok_count, E_NONE);
                            tok_begin = at + 1;
                            tok_count = 0;
                            phase     = P_VAL;
                        end else if (b == CH_CR || b == CH_NUL) begin
                            abort_at(at, E_NO_COLON);
                        end else begin
                            tok_count++;
                        end
                    end
                    P_VAL: begin
                        if (b == CH_CR) begin
                            add_token(K_VALUE, tok_begin, tok_count, E_NONE);
                            phase = P_HDR_SKIP;
                        end else begin
                            tok_count++;
                        end
                    end
                    default: phase = P_DONE;
                endcase
            end
        end
        foreach (byte_tokens[i]) begin
            t = byte_tokens[i];
            t.last_of_run = (i == byte_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ---------------- stimulus building ----------------

    function automatic void push_byte(logic [7:0] b, logic sor);
        in_t item;
        item.data_byte        = b;
        item.start_of_request = sor;
        pending_bytes.push_back(item);
    endfunction

    function automatic void push_text(string s, logic sor);
        foreach (s[i]) push_byte(s[i], sor && i == 0);
    endfunction

    function automatic logic [7:0] any_byte_but(logic [7:0] x1, logic [7:0] x2,
                                                logic [7:0] x3);
        logic [7:0] b;
        do begin
            b = chance(80) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
        end while (b == x1 || b == x2 || b == x3);
        return b;
    endfunction

    function automatic void push_run(int n, logic [7:0] x1, logic [7:0] x2,
                                     logic [7:0] x3);
        repeat (n) push_byte(any_byte_but(x1, x2, x3), 1'b0);
    endfunction

    function automatic void push_line_end();
        push_byte(CH_CR, 1'b0);
        push_byte(chance(90) ? CH_LF : any_byte_but(CH_LF, CH_LF, CH_LF), 1'b0);
    endfunction

    function automatic void queue_request();
        logic [7:0] b;
        int         r;
        if (chance(4)) begin
            do b = 8'($urandom_range(0, 255)); while (b >= CH_A && b <= CH_Z);
        end else begin
            b = 8'($urandom_range(CH_A, CH_Z));
        end
        push_byte(b, 1'b1);
        push_run($urandom_range(0, 5), CH_SP, CH_CR, CH_SP);
        if (chance(3)) begin
            push_byte(CH_CR, 1'b0);
            return;
        end
        push_byte(CH_SP, 1'b0);
        push_run(chance(5) ? 0 : $urandom_range(1, 12), CH_SP, CH_CR, CH_SP);
        if (chance(15)) begin
            push_line_end();
        end else begin
            push_byte(CH_SP, 1'b0);
            if (chance(15)) ;
            else if (chance(50)) push_text("HTTP/1.1", 1'b0);
            else push_run($urandom_range(1, 10), CH_CR, CH_CR, CH_CR);
            push_line_end();
        end
        repeat ($urandom_range(0, 4)) begin
            if (chance(5)) begin
                // key cut short by CR or NUL
                push_run($urandom_range(0, 4), CH_COLON, CH_CR, CH_NUL);
                push_byte(chance(50) ? CH_CR : CH_NUL, 1'b0);
                return;
            end
            if (chance(6)) begin
                push_byte(CH_CR, 1'b0);
                b = any_byte_but(CH_LF, CH_CR, CH_NUL);
                push_byte(b, 1'b0);
                if (b != CH_COLON) begin
                    push_run($urandom_range(0, 6), CH_COLON, CH_CR, CH_NUL);
                    push_byte(CH_COLON, 1'b0);
                end
            end else begin
                push_run(chance(5) ? 0 : $urandom_range(1, 8), CH_COLON, CH_CR, CH_NUL);
                push_byte(CH_COLON, 1'b0);
            end
            if (chance(80)) push_byte(CH_SP, 1'b0);
            push_run($urandom_range(0, 12), CH_CR, CH_CR, CH_CR);
            push_line_end();
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            push_byte(CH_CR, 1'b0);
            push_byte(CH_LF, 1'b0);
        end else if (r < 80) begin
            push_byte(CH_NUL, 1'b0);
        end else if (r < 93) begin
            push_byte(CH_CR, 1'b0);
            push_byte(r < 87 ? CH_CR : CH_NUL, 1'b0);
        end
        // trailing no-start bytes are dropped by a done parser, else a NUL ends it
        if (chance(20)) push_run($urandom_range(1, 3), CH_NUL, CH_NUL, CH_NUL);
    endfunction

    // Long URL and a header value that runs past MAX_REQUEST_BYTES.
    function automatic void queue_long_request();
        push_text("GET ", 1'b1);
        push_run($urandom_range(1000, 1005), CH_SP, CH_CR, CH_SP);
        push_line_end();
        push_text("K: ", 1'b0);
        push_run($urandom_range(20, 150), CH_CR, CH_CR, CH_CR);
        push_line_end();
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
    endfunction

    // ---------------- input side ----------------

    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_bytes.size() != 0) begin
                s_valid   <= 1'b1;
                s_payload <= pending_bytes.pop_front();
                gap_left  <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- output side: check, predict, back-pressure ----------------

    int stall_left  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int bytes_taken = 0;

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token with nothing expected: kind %0d start %0d length %0d",
                           m_payload.token_kind, m_payload.token_start,
                           m_payload.token_length);
                    mismatches++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.token_kind, m_payload.token_kind);
                    check_field("token_start", want.token_start, m_payload.token_start);
                    check_field("token_length", want.token_length, m_payload.token_length);
                    check_field("error_code", want.error_code, m_payload.error_code);
                    check_field("last_of_run", want.last_of_run, m_payload.last_of_run);
                end
            end
            if (s_valid && s_ready) begin
                tokenize_byte(s_payload);
                bytes_taken++;
            end
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && bytes_taken >= HOLD_AT) begin
                // long hold-off so the result queue fills and s_ready drops
                m_ready   <= 1'b0;
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end else if (stall_left > 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if ($urandom_range(0, 249) == 0) calm <= ~calm;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int base;
        bit long_done;
        long_done = 1'b0;

        push_byte(8'h47, 1'b0);          // idle parser drops it
        push_byte(8'h40, 1'b1);          // bad first byte
        push_byte(CH_NUL, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_text("Z", 1'b1);            // no space on the line
        push_byte(CH_CR, 1'b0);
        push_text("A ", 1'b1);           // empty URL closed by CR
        push_byte(CH_CR, 1'b0);
        push_text("A  ", 1'b1);          // empty URL closed by space
        push_text("A /", 1'b1);          // URL closed by CR, then blank line
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(8'h58, 1'b0);          // after end of headers: dropped
        push_text("A /  V", 1'b1);       // extra spaces, empty key and value
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_text(":", 1'b0);
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(CH_NUL, 1'b0);

        base = pending_bytes.size();
        while (pending_bytes.size() - base < RANDOM_BYTES) begin
            if (!long_done && pending_bytes.size() - base > RANDOM_BYTES / 4) begin
                queue_long_request();
                long_done = 1'b1;
            end
            queue_request();
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid) @(negedge aclk);
        while (expected_tokens.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
